// ===== hdl/obm_pkg.sv =====
// Shared types and constants for the order book matching block.
// No dependencies.
`default_nettype none
package obm_pkg;

  localparam int OBM_BOOK_DEPTH  = 32;
  localparam int OBM_QUEUE_DEPTH = 2;
  localparam int PRICE_W = 31;
  localparam int QTY_W   = 31;
  localparam int TAG_W   = 32;

  localparam logic [1:0] REQ_NEW    = 2'd0;
  localparam logic [1:0] REQ_MODIFY = 2'd1;
  localparam logic [1:0] REQ_CANCEL = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic KIND_TRADE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic SIDE_BID = 1'b0;
  localparam logic SIDE_ASK = 1'b1;

  typedef enum logic [1:0] {
    OP_NEW,
    OP_MODIFY,
    OP_CANCEL,
    OP_IGNORE
  } op_t;

  typedef struct packed {
    op_t                op;
    logic               side;
    logic               ioc;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic [TAG_W-1:0]   tag;
  } req_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CXL_BID,
    ST_CXL_ASK,
    ST_MATCH,
    ST_STATUS
  } back_state_t;

endpackage
`default_nettype wire

// ===== hdl/obm_front.sv =====
// Front end: takes requests on the command port and decodes them into queue entries.
// Depends on obm_pkg.
`default_nettype none
module obm_front
  import obm_pkg::*;
(
  input  wire logic               start,
  input  wire logic [1:0]         req_type,
  input  wire logic               side,
  input  wire logic               immediate_or_cancel,
  input  wire logic [PRICE_W-1:0] limit_price,
  input  wire logic [QTY_W-1:0]   order_qty,
  input  wire logic [TAG_W-1:0]   order_tag,
  input  wire logic               queue_full,
  output logic                    busy,
  output logic                    push,
  output req_entry_t              entry
);

  op_t op;

  always_comb begin
    unique case (req_type)
      REQ_NEW:    op = OP_NEW;
      REQ_MODIFY: op = OP_MODIFY;
      REQ_CANCEL: op = OP_CANCEL;
      default:    op = OP_IGNORE;
    endcase
  end

  assign busy = queue_full;
  assign push = start && !queue_full;

  always_comb begin
    entry.op    = op;
    entry.side  = side;
    // modify always re-enters as good for day
    entry.ioc   = (op == OP_MODIFY) ? 1'b0 : immediate_or_cancel;
    entry.price = limit_price;
    // requests that never rest carry no quantity
    entry.qty   = (op == OP_NEW || op == OP_MODIFY) ? order_qty : '0;
    entry.tag   = order_tag;
  end

endmodule
`default_nettype wire

// ===== hdl/obm_queue.sv =====
// Short request queue between the front end and the matching back end.
// Depends on obm_pkg.
`default_nettype none
module obm_queue
  import obm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  req_entry_t      push_entry,
  input  wire logic       pop,
  output logic            full,
  output logic            valid,
  output req_entry_t      head
);

  localparam int PW = (OBM_QUEUE_DEPTH > 1) ? $clog2(OBM_QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(OBM_QUEUE_DEPTH + 1);

  req_entry_t     slots [OBM_QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  fill;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(OBM_QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full  = (fill == CW'(OBM_QUEUE_DEPTH));
  assign valid = (fill != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop)      fill <= fill + CW'(1);
      else if (pop && !push) fill <= fill - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

endmodule
`default_nettype wire

// ===== hdl/obm_back.sv =====
// Back end: holds both books, runs cancel scans, matching and resting, emits records.
// Depends on obm_pkg.
`default_nettype none
module obm_back
  import obm_pkg::*;
#(
  parameter int BOOK_DEPTH = OBM_BOOK_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_valid,
  input  req_entry_t              q_head,
  output logic                    pop,
  output logic                    strobe,
  output logic                    record_kind,
  output logic [TAG_W-1:0]        resting_tag,
  output logic [PRICE_W-1:0]      resting_price,
  output logic [TAG_W-1:0]        incoming_tag,
  output logic [PRICE_W-1:0]      incoming_price,
  output logic [QTY_W-1:0]        traded_qty,
  output logic [QTY_W-1:0]        rested_qty,
  output logic                    found_flag,
  output logic                    book_full,
  output logic                    last_record
);

  localparam int CW = $clog2(BOOK_DEPTH + 1);
  localparam int IW = $clog2(BOOK_DEPTH);

  back_state_t state, state_next;

  req_entry_t          cur;
  logic [QTY_W-1:0]    qty;
  logic                found;
  logic [CW-1:0]       scan;

  // index 0 is the bid book, 1 the ask book
  logic [PRICE_W-1:0]  book_price [2][BOOK_DEPTH];
  logic [QTY_W-1:0]    book_qty   [2][BOOK_DEPTH];
  logic [TAG_W-1:0]    book_tag   [2][BOOK_DEPTH];
  logic [CW-1:0]       count      [2];

  logic                bk;
  logic                own;
  logic                in_range;
  logic [PRICE_W-1:0]  rd_price;
  logic [QTY_W-1:0]    rd_qty;
  logic [TAG_W-1:0]    rd_tag;
  logic                hit;
  logic                tag_hit;
  logic                scanning;
  logic                trade;
  logic                drop;
  logic                reduce;
  logic                rest_ok;
  logic                rest_full;
  logic                found_any;

  assign own      = cur.side;
  assign in_range = (scan < count[bk]);
  assign rd_price = book_price[bk][scan[IW-1:0]];
  assign rd_qty   = book_qty[bk][scan[IW-1:0]];
  assign rd_tag   = book_tag[bk][scan[IW-1:0]];
  assign tag_hit  = (rd_tag == cur.tag);
  assign hit      = (cur.side == SIDE_BID) ? (rd_price <= cur.price) : (rd_price >= cur.price);
  assign found_any = found || (in_range && tag_hit);

  // outputs / control decode
  always_comb begin
    pop       = 1'b0;
    bk        = ~cur.side;
    scanning  = 1'b0;
    trade     = 1'b0;
    drop      = 1'b0;
    reduce    = 1'b0;
    rest_ok   = 1'b0;
    rest_full = 1'b0;
    unique case (state)
      ST_IDLE: begin
        pop = q_valid;
      end
      ST_CXL_BID: begin
        bk   = SIDE_BID;
        drop = in_range && tag_hit;
      end
      ST_CXL_ASK: begin
        bk   = SIDE_ASK;
        drop = in_range && tag_hit;
      end
      ST_MATCH: begin
        bk       = ~cur.side;
        scanning = in_range && (qty != '0);
        trade    = scanning && hit;
        drop     = trade && (rd_qty <= qty);
        reduce   = trade && (rd_qty > qty);
      end
      ST_STATUS: begin
        rest_ok   = (qty != '0) && !cur.ioc && (count[own] < CW'(BOOK_DEPTH));
        rest_full = (qty != '0) && !cur.ioc && (count[own] >= CW'(BOOK_DEPTH));
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_head.op) inside
            OP_NEW:               state_next = ST_MATCH;
            OP_MODIFY, OP_CANCEL: state_next = ST_CXL_BID;
            default:              state_next = ST_STATUS;
          endcase
        end
      end
      ST_CXL_BID: begin
        if (!in_range || tag_hit) state_next = ST_CXL_ASK;
      end
      ST_CXL_ASK: begin
        if (!in_range || tag_hit)
          state_next = (cur.op == OP_MODIFY && found_any) ? ST_MATCH : ST_STATUS;
      end
      ST_MATCH: begin
        if (!(in_range && (qty != '0))) state_next = ST_STATUS;
      end
      ST_STATUS: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count[0] <= '0;
      count[1] <= '0;
      strobe   <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= trade || (state == ST_STATUS);
      if (drop)
        count[bk] <= count[bk] - CW'(1);
      if (rest_ok)
        count[own] <= count[own] + CW'(1);
    end
  end

  // working registers and book contents
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          cur   <= q_head;
          qty   <= q_head.qty;
          found <= 1'b0;
          scan  <= '0;
        end
      end
      ST_CXL_BID: begin
        if (!in_range || tag_hit) scan <= '0;
        else                      scan <= scan + CW'(1);
        if (in_range && tag_hit)  found <= 1'b1;
      end
      ST_CXL_ASK: begin
        if (!in_range || tag_hit) begin
          scan  <= '0;
          found <= found_any;
          if (!(cur.op == OP_MODIFY && found_any)) qty <= '0;
        end else begin
          scan <= scan + CW'(1);
        end
      end
      ST_MATCH: begin
        if (scanning && !hit) scan <= scan + CW'(1);
        if (reduce) qty <= '0;
        if (drop)   qty <= qty - rd_qty;
      end
      default: ;
    endcase

    // compaction: entries after the removed one move up by one
    if (drop) begin
      for (int j = 0; j < BOOK_DEPTH - 1; j++) begin
        if (CW'(j) >= scan) begin
          book_price[bk][j] <= book_price[bk][j+1];
          book_qty[bk][j]   <= book_qty[bk][j+1];
          book_tag[bk][j]   <= book_tag[bk][j+1];
        end
      end
    end
    if (reduce)
      book_qty[bk][scan[IW-1:0]] <= rd_qty - qty;
    if (rest_ok) begin
      book_price[own][count[own][IW-1:0]] <= cur.price;
      book_qty[own][count[own][IW-1:0]]   <= qty;
      book_tag[own][count[own][IW-1:0]]   <= cur.tag;
    end
  end

  // record register
  always_ff @(posedge clk) begin
    if (trade) begin
      record_kind    <= KIND_TRADE;
      resting_tag    <= rd_tag;
      resting_price  <= rd_price;
      incoming_tag   <= cur.tag;
      incoming_price <= cur.price;
      traded_qty     <= reduce ? qty : rd_qty;
      rested_qty     <= '0;
      found_flag     <= 1'b0;
      book_full      <= 1'b0;
      last_record    <= 1'b0;
    end else begin
      record_kind    <= KIND_STATUS;
      resting_tag    <= '0;
      resting_price  <= '0;
      incoming_tag   <= '0;
      incoming_price <= '0;
      traded_qty     <= '0;
      rested_qty     <= rest_ok ? qty : '0;
      found_flag     <= found;
      book_full      <= rest_full;
      last_record    <= 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/order_book_matching.sv =====
// Request handling: busy is high only while the two-entry request queue is full, so up to two
// requests can wait while one is being worked on. Records leave at most one per cycle on
// strobe and the receiver cannot stall them; each request gives its trades, then one status
// record with last_record set. Time per request is set by the single scan pointer of the back
// end, one book entry per cycle: a cancel scans the bid book, then the ask book, for its tag;
// a new order scans the opposite book; a modify that finds its tag adds the new-order scan.
// No clearing pass is needed after reset.
// Depends on obm_pkg, obm_front, obm_queue, obm_back.
`default_nettype none
module order_book_matching
  import obm_pkg::*;
#(
  parameter int BOOK_DEPTH = OBM_BOOK_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         req_type,
  input  wire logic               side,
  input  wire logic               immediate_or_cancel,
  input  wire logic [PRICE_W-1:0] limit_price,
  input  wire logic [QTY_W-1:0]   order_qty,
  input  wire logic [TAG_W-1:0]   order_tag,
  output logic                    strobe,
  output logic                    record_kind,
  output logic [TAG_W-1:0]        resting_tag,
  output logic [PRICE_W-1:0]      resting_price,
  output logic [TAG_W-1:0]        incoming_tag,
  output logic [PRICE_W-1:0]      incoming_price,
  output logic [QTY_W-1:0]        traded_qty,
  output logic [QTY_W-1:0]        rested_qty,
  output logic                    found_flag,
  output logic                    book_full,
  output logic                    last_record
);

  req_entry_t push_entry;
  req_entry_t q_head;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_valid;

  obm_front u_front (
    .start               (start),
    .req_type            (req_type),
    .side                (side),
    .immediate_or_cancel (immediate_or_cancel),
    .limit_price         (limit_price),
    .order_qty           (order_qty),
    .order_tag           (order_tag),
    .queue_full          (q_full),
    .busy                (busy),
    .push                (push),
    .entry               (push_entry)
  );

  obm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .valid      (q_valid),
    .head       (q_head)
  );

  obm_back #(
    .BOOK_DEPTH (BOOK_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .pop            (pop),
    .strobe         (strobe),
    .record_kind    (record_kind),
    .resting_tag    (resting_tag),
    .resting_price  (resting_price),
    .incoming_tag   (incoming_tag),
    .incoming_price (incoming_price),
    .traded_qty     (traded_qty),
    .rested_qty     (rested_qty),
    .found_flag     (found_flag),
    .book_full      (book_full),
    .last_record    (last_record)
  );

endmodule
`default_nettype wire

// ===== tb/obm_checker.sv =====
// Order book checker: mirrors both books, predicts the records each accepted request
// yields, and compares every strobed record with the oldest prediction.
// Depends on obm_pkg.
`timescale 1ns / 1ps
module obm_checker
  import obm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic [1:0]         req_type,
  input  wire logic               side,
  input  wire logic               immediate_or_cancel,
  input  wire logic [PRICE_W-1:0] limit_price,
  input  wire logic [QTY_W-1:0]   order_qty,
  input  wire logic [TAG_W-1:0]   order_tag,
  input  wire logic               strobe,
  input  wire logic               record_kind,
  input  wire logic [TAG_W-1:0]   resting_tag,
  input  wire logic [PRICE_W-1:0] resting_price,
  input  wire logic [TAG_W-1:0]   incoming_tag,
  input  wire logic [PRICE_W-1:0] incoming_price,
  input  wire logic [QTY_W-1:0]   traded_qty,
  input  wire logic [QTY_W-1:0]   rested_qty,
  input  wire logic               found_flag,
  input  wire logic               book_full,
  input  wire logic               last_record,
  output int                      fail_count,
  output int                      pending,
  output int                      bid_depth,
  output int                      ask_depth
);

  typedef struct packed {
    logic               kind;
    logic [TAG_W-1:0]   rtag;
    logic [PRICE_W-1:0] rprice;
    logic [TAG_W-1:0]   itag;
    logic [PRICE_W-1:0] iprice;
    logic [QTY_W-1:0]   tqty;
    logic [QTY_W-1:0]   rqty;
    logic               found;
    logic               full;
    logic               last;
  } fill_rec_t;

  typedef struct {
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic [TAG_W-1:0]   tag;
  } resting_t;

  resting_t  bids[$];
  resting_t  asks[$];
  fill_rec_t fills_due[$];

  assign pending   = fills_due.size();
  assign bid_depth = bids.size();
  assign ask_depth = asks.size();

  function automatic fill_rec_t status_rec(logic [QTY_W-1:0] rq, logic fnd, logic full);
    fill_rec_t r;
    r = '0;
    r.kind = KIND_STATUS; r.rqty = rq; r.found = fnd; r.full = full; r.last = 1'b1;
    return r;
  endfunction

  function automatic bit drop_tag(ref resting_t bk[$], input logic [TAG_W-1:0] tg);
    foreach (bk[i])
      if (bk[i].tag == tg) begin
        bk.delete(i);
        return 1'b1;
      end
    return 1'b0;
  endfunction

  task automatic match_order(input logic sd, input logic ioc, input logic [PRICE_W-1:0] px,
                             input logic [QTY_W-1:0] qty_in, input logic [TAG_W-1:0] tg,
                             input logic fnd);
    logic [QTY_W-1:0] q;
    logic [QTY_W-1:0] rested;
    logic full;
    fill_rec_t r;
    int i;
    q = qty_in; rested = '0; full = 1'b0; i = 0;
    while (q != 0) begin
      resting_t e;
      bit hit;
      if (sd == SIDE_BID) begin
        if (i >= asks.size()) break;
        e = asks[i];
        hit = e.price <= px;
      end else begin
        if (i >= bids.size()) break;
        e = bids[i];
        hit = e.price >= px;
      end
      if (!hit) begin
        i++;
        continue;
      end
      r = '0;
      r.rtag = e.tag; r.rprice = e.price; r.itag = tg; r.iprice = px;
      if (e.qty > q) begin
        r.tqty = q;
        if (sd == SIDE_BID) asks[i].qty = e.qty - q; else bids[i].qty = e.qty - q;
        q = '0;
      end else begin
        r.tqty = e.qty;
        q = q - e.qty;
        if (sd == SIDE_BID) asks.delete(i); else bids.delete(i);
      end
      fills_due.push_back(r);
    end
    if (q != 0 && !ioc) begin
      resting_t n;
      n.price = px; n.qty = q; n.tag = tg;
      if (sd == SIDE_BID) begin
        if (bids.size() < OBM_BOOK_DEPTH) begin bids.push_back(n); rested = q; end
        else full = 1'b1;
      end else begin
        if (asks.size() < OBM_BOOK_DEPTH) begin asks.push_back(n); rested = q; end
        else full = 1'b1;
      end
    end
    fills_due.push_back(status_rec(rested, fnd, full));
  endtask

  task automatic book_request();
    bit fnd;
    case (req_type) inside
      REQ_NEW: match_order(side, immediate_or_cancel, limit_price, order_qty, order_tag, 1'b0);
      REQ_MODIFY, REQ_CANCEL: begin
        fnd = drop_tag(bids, order_tag);
        if (drop_tag(asks, order_tag)) fnd = 1'b1;
        if (req_type == REQ_MODIFY && fnd)
          match_order(side, 1'b0, limit_price, order_qty, order_tag, 1'b1);
        else
          fills_due.push_back(status_rec('0, fnd, 1'b0));
      end
      default: fills_due.push_back(status_rec('0, 1'b0, 1'b0));
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fail_count <= 0;
    end else begin
      // records out first: a request accepted this edge cannot already have a record out
      if (strobe) begin
        if (fills_due.size() == 0) begin
          $error("record with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          fill_rec_t x;
          int bad;
          x = fills_due.pop_front();
          bad = 0;
          if (record_kind !== x.kind) begin
            $error("record_kind exp %0d got %0d", x.kind, record_kind); bad++; end
          if (resting_tag !== x.rtag) begin
            $error("resting_tag exp %0d got %0d", x.rtag, resting_tag); bad++; end
          if (resting_price !== x.rprice) begin
            $error("resting_price exp %0d got %0d", x.rprice, resting_price); bad++; end
          if (incoming_tag !== x.itag) begin
            $error("incoming_tag exp %0d got %0d", x.itag, incoming_tag); bad++; end
          if (incoming_price !== x.iprice) begin
            $error("incoming_price exp %0d got %0d", x.iprice, incoming_price); bad++; end
          if (traded_qty !== x.tqty) begin
            $error("traded_qty exp %0d got %0d", x.tqty, traded_qty); bad++; end
          if (rested_qty !== x.rqty) begin
            $error("rested_qty exp %0d got %0d", x.rqty, rested_qty); bad++; end
          if (found_flag !== x.found) begin
            $error("found_flag exp %0d got %0d", x.found, found_flag); bad++; end
          if (book_full !== x.full) begin
            $error("book_full exp %0d got %0d", x.full, book_full); bad++; end
          if (last_record !== x.last) begin
            $error("last_record exp %0d got %0d", x.last, last_record); bad++; end
          if (bad != 0) fail_count <= fail_count + 1;
        end
      end
      if (start && !busy) book_request();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the order book testbench: clock, reset, request stimulus and verdict.
// Depends on obm_pkg, order_book_matching and obm_checker.
`timescale 1ns / 1ps
module tb_top;
  import obm_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         req_type = REQ_CANCEL;
  logic               side = SIDE_BID;
  logic               immediate_or_cancel = 1'b0;
  logic [PRICE_W-1:0] limit_price = '0;
  logic [QTY_W-1:0]   order_qty = '0;
  logic [TAG_W-1:0]   order_tag = '0;
  logic               strobe, record_kind, found_flag, book_full, last_record;
  logic [TAG_W-1:0]   resting_tag, incoming_tag;
  logic [PRICE_W-1:0] resting_price, incoming_price;
  logic [QTY_W-1:0]   traded_qty, rested_qty;
  int fail_count, pending, bid_depth, ask_depth;
  int cycles = 0;
  logic [TAG_W-1:0] tags_used[$];

  localparam int CYCLE_LIMIT = 400000;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  order_book_matching uut (.*);

  obm_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send(input logic [1:0] rt, input logic sd, input logic ioc,
                      input logic [PRICE_W-1:0] px, input logic [QTY_W-1:0] q,
                      input logic [TAG_W-1:0] tg);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
    repeat (gap) @(posedge clk);
    start <= 1'b1; req_type <= rt; side <= sd; immediate_or_cancel <= ioc;
    limit_price <= px; order_qty <= q; order_tag <= tg;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    if (rt == REQ_NEW || rt == REQ_MODIFY) tags_used.push_back(tg);
  endtask

  // mostly mid-range prices so books cross often; a few extremes
  function automatic logic [PRICE_W-1:0] pick_price();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return PRICE_W'($urandom);
    return PRICE_W'(1000 + $urandom_range(0, 40));
  endfunction

  function automatic logic [QTY_W-1:0] pick_qty();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return QTY_W'($urandom);
    return QTY_W'($urandom_range(1, 60));
  endfunction

  function automatic logic [TAG_W-1:0] pick_tag();
    if (tags_used.size() != 0 && $urandom_range(0, 1))
      return tags_used[$urandom_range(0, tags_used.size() - 1)];
    return $urandom;
  endfunction

  initial begin
    int k;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // directed
    send(REQ_NEW, SIDE_BID, 0, '1, '1, '1);
    send(REQ_NEW, SIDE_ASK, 0, '0, 5, 32'h1);
    send(REQ_NEW, SIDE_ASK, 0, '0, 0, 32'h2);       // zero quantity
    send(REQ_NEW, SIDE_ASK, 1, 100, 50, 32'h3);     // IOC, fills against the resting bid
    send(REQ_NEW, SIDE_ASK, 0, 100, 50, 32'h4);
    send(REQ_NEW, SIDE_BID, 0, 99, 7, 32'h5);
    send(REQ_NEW, SIDE_BID, 1, 100, 10, 32'h6);     // IOC, finds no resting ask
    send(REQ_MODIFY, SIDE_BID, 0, 200, 60, 32'h4);  // not found, tag 4 traded away
    send(REQ_MODIFY, SIDE_ASK, 0, 10, 1, 32'hDEAD); // not found
    send(REQ_CANCEL, SIDE_ASK, 1, '1, '1, 32'h5);
    send(REQ_CANCEL, SIDE_BID, 0, 0, 0, 32'h5);
    send(REQ_UNUSED, SIDE_ASK, 1, '1, '1, '1);
    send(REQ_CANCEL, SIDE_BID, 0, 0, 0, '1);
    // fill the bid book past its depth, then sweep it with one big sell
    for (k = 0; k < OBM_BOOK_DEPTH + 2; k++)
      send(REQ_NEW, SIDE_BID, 0, PRICE_W'(500 + k), 3, TAG_W'(100 + k));
    send(REQ_NEW, SIDE_ASK, 1, 1, '1, 32'h77);
    send(REQ_NEW, SIDE_BID, 1, 0, 3, 32'h78);
    // hold until everything is drained
    while (pending != 0) @(posedge clk);
    // random
    for (k = 0; k < 460; k++) begin
      int r;
      logic [1:0] rt;
      r = $urandom_range(0, 19);
      rt = r < 13 ? REQ_NEW : r < 16 ? REQ_CANCEL : r < 19 ? REQ_MODIFY : REQ_UNUSED;
      send(rt, 1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0,
           pick_price(), pick_qty(), pick_tag());
      if (k == 230)
        while (pending != 0) @(posedge clk);
    end
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
